FILE: sv/msu_pkg.sv
`default_nettype none

package msu_pkg;

    localparam int RegCount = 32;
    localparam int AddrWidth = $clog2(RegCount);
    localparam int DataWidth = 64;
    localparam int OpWidth = 4;

    // Instruction codes.
    localparam logic [OpWidth-1:0] OP_SLL    = 4'd0;
    localparam logic [OpWidth-1:0] OP_SRL    = 4'd1;
    localparam logic [OpWidth-1:0] OP_SRA    = 4'd2;
    localparam logic [OpWidth-1:0] OP_DSLL   = 4'd3;
    localparam logic [OpWidth-1:0] OP_DSRL   = 4'd4;
    localparam logic [OpWidth-1:0] OP_DSRA   = 4'd5;
    localparam logic [OpWidth-1:0] OP_DSLL32 = 4'd6;
    localparam logic [OpWidth-1:0] OP_DSRL32 = 4'd7;
    localparam logic [OpWidth-1:0] OP_DSRA32 = 4'd8;
    localparam logic [OpWidth-1:0] OP_SLLV   = 4'd9;
    localparam logic [OpWidth-1:0] OP_SRLV   = 4'd10;
    localparam logic [OpWidth-1:0] OP_SRAV   = 4'd11;
    localparam logic [OpWidth-1:0] OP_DSLLV  = 4'd12;
    localparam logic [OpWidth-1:0] OP_DSRLV  = 4'd13;
    localparam logic [OpWidth-1:0] OP_DSRAV  = 4'd14;
    localparam logic [OpWidth-1:0] OP_LOAD   = 4'd15;

    // Where the shift amount comes from.
    localparam logic [1:0] AMT_SA   = 2'd0;
    localparam logic [1:0] AMT_SA32 = 2'd1;
    localparam logic [1:0] AMT_RS5  = 2'd2;
    localparam logic [1:0] AMT_RS6  = 2'd3;

    typedef struct packed {
        logic [1:0] amt_sel;
        logic       is32;
        logic       left;
        logic       arith;
        logic       load;
    } shift_ctl_t;

    function automatic shift_ctl_t decode_op(input logic [OpWidth-1:0] op);
        shift_ctl_t c;
        c = '0;
        case (op)
            OP_SLL:    begin c.amt_sel = AMT_SA;   c.is32 = 1'b1; c.left = 1'b1; end
            OP_SRL:    begin c.amt_sel = AMT_SA;   c.is32 = 1'b1; end
            OP_SRA:    begin c.amt_sel = AMT_SA;   c.is32 = 1'b1; c.arith = 1'b1; end
            OP_DSLL:   begin c.amt_sel = AMT_SA;   c.left = 1'b1; end
            OP_DSRL:   begin c.amt_sel = AMT_SA;   end
            OP_DSRA:   begin c.amt_sel = AMT_SA;   c.arith = 1'b1; end
            OP_DSLL32: begin c.amt_sel = AMT_SA32; c.left = 1'b1; end
            OP_DSRL32: begin c.amt_sel = AMT_SA32; end
            OP_DSRA32: begin c.amt_sel = AMT_SA32; c.arith = 1'b1; end
            OP_SLLV:   begin c.amt_sel = AMT_RS5;  c.is32 = 1'b1; c.left = 1'b1; end
            OP_SRLV:   begin c.amt_sel = AMT_RS5;  c.is32 = 1'b1; end
            OP_SRAV:   begin c.amt_sel = AMT_RS5;  c.is32 = 1'b1; c.arith = 1'b1; end
            OP_DSLLV:  begin c.amt_sel = AMT_RS6;  c.left = 1'b1; end
            OP_DSRLV:  begin c.amt_sel = AMT_RS6;  end
            OP_DSRAV:  begin c.amt_sel = AMT_RS6;  c.arith = 1'b1; end
            default:   begin c.load = 1'b1; end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/msu_regfile.sv
`default_nettype none

module msu_regfile (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [msu_pkg::AddrWidth-1:0] rd_addr_a,
    input  wire logic [msu_pkg::AddrWidth-1:0] rd_addr_b,
    output logic      [msu_pkg::DataWidth-1:0] rd_data_a,
    output logic      [msu_pkg::DataWidth-1:0] rd_data_b,
    input  wire logic                          wr_en,
    input  wire logic [msu_pkg::AddrWidth-1:0] wr_addr,
    input  wire logic [msu_pkg::DataWidth-1:0] wr_data
);
    import msu_pkg::*;

    logic [DataWidth-1:0] mem_reg [RegCount];
    logic [RegCount-1:0]  valid_reg;
    logic [DataWidth-1:0] data_a_reg;
    logic [DataWidth-1:0] data_b_reg;
    logic                 valid_a_reg;
    logic                 valid_b_reg;

    // Storage and registered read data; no reset on the array itself.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem_reg[rd_addr_a];
            data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    // An entry that was never written since reset reads as zero. Entry zero
    // is not guarded here; the shift unit never writes it, so it stays zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                valid_a_reg <= valid_reg[rd_addr_a];
                valid_b_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = valid_a_reg ? data_a_reg : '0;
    assign rd_data_b = valid_b_reg ? data_b_reg : '0;

endmodule

`default_nettype wire

FILE: sv/msu_shifter.sv
`default_nettype none

module msu_shifter (
    input  wire msu_pkg::shift_ctl_t          ctl,
    input  wire logic [4:0]                   sa,
    input  wire logic [msu_pkg::DataWidth-1:0] rs_val,
    input  wire logic [msu_pkg::DataWidth-1:0] rt_val,
    input  wire logic [msu_pkg::DataWidth-1:0] load_value,
    output logic      [msu_pkg::DataWidth-1:0] result
);
    import msu_pkg::*;

    logic [5:0]           amt;
    logic [DataWidth-1:0] src;
    logic [DataWidth-1:0] shifted;

    always_comb
    begin
        case (ctl.amt_sel)
            AMT_SA:   amt = {1'b0, sa};
            AMT_SA32: amt = {1'b1, sa};
            AMT_RS5:  amt = {1'b0, rs_val[4:0]};
            AMT_RS6:  amt = rs_val[5:0];
            default:  amt = '0;
        endcase
    end

    // The word forms reuse the doubleword shifter: the low word is extended
    // (by sign for arithmetic shifts) and the low 32 bits of the result kept and sign-extended.
    always_comb
    begin
        if (ctl.is32)
        begin
            src = ctl.arith ? {{32{rt_val[31]}}, rt_val[31:0]} : {32'b0, rt_val[31:0]};
        end
        else
        begin
            src = rt_val;
        end

        if (ctl.left)
        begin
            shifted = src << amt;
        end
        else if (ctl.arith)
        begin
            shifted = $unsigned($signed(src) >>> amt);
        end
        else
        begin
            shifted = src >> amt;
        end

        if (ctl.load)
        begin
            result = load_value;
        end
        else if (ctl.is32)
        begin
            result = {{32{shifted[31]}}, shifted[31:0]};
        end
        else
        begin
            result = shifted;
        end
    end

endmodule

`default_nettype wire

FILE: sv/mips64_shift_unit.sv
`default_nettype none

// Shift execute unit with its own 32 x 64-bit register file.
//
// Command channel: an instruction beat (op, dest_reg, value_reg, amount_reg,
// shift_field, load_value) is taken at a rising edge where start is high and
// busy is low. The unit then reads rt and rs from the register file, shifts,
// writes the result back to rd unless rd is register zero, and presents the
// result beat on written_reg, result_value and was_written with done high for
// exactly one cycle.
//
// Fields and operands are registered at the accepting edge; done is then
// registered from exec_reg at the end of the execute cycle. The unit takes no
// new instruction while busy: the synchronous register file read is followed
// by the shift and write-back, and busy is high for the one cycle in between.
// The next instruction may be accepted in the same cycle that done is shown,
// and it sees the previous write-back.
//
// Reset clears all control state and marks every register as zero; no
// clearing pass is needed. The receiver cannot stall: each result beat is
// valid only while done is high.
module mips64_shift_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  op,
    input  wire logic [4:0]  dest_reg,
    input  wire logic [4:0]  value_reg,
    input  wire logic [4:0]  amount_reg,
    input  wire logic [4:0]  shift_field,
    input  wire logic [63:0] load_value,
    output logic             done,
    output logic [4:0]       written_reg,
    output logic [63:0]      result_value,
    output logic             was_written
);
    import msu_pkg::*;

    logic                 accept;
    logic                 exec_reg;
    logic                 exec_next;
    shift_ctl_t           ctl_reg;
    logic [AddrWidth-1:0] dest_q_reg;
    logic [4:0]           sa_reg;
    logic [DataWidth-1:0] load_q_reg;

    logic [DataWidth-1:0] rt_val;
    logic [DataWidth-1:0] rs_val;
    logic [DataWidth-1:0] shift_result;
    logic                 wb_en;

    logic                 done_reg;
    logic                 done_next;
    logic [AddrWidth-1:0] out_dest_reg;
    logic [DataWidth-1:0] out_value_reg;
    logic                 out_we_reg;

    assign accept    = start && !busy;
    assign exec_next = accept;
    assign done_next = exec_reg;

    // The write-back happens in the execute cycle; register zero is never
    // written, so it keeps reading as zero.
    assign wb_en = exec_reg && (dest_q_reg != '0);

    // Register file read is launched on the accepting edge, so the operands
    // arrive together with the captured instruction fields.
    msu_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (value_reg),
        .rd_addr_b (amount_reg),
        .rd_data_a (rt_val),
        .rd_data_b (rs_val),
        .wr_en     (wb_en),
        .wr_addr   (dest_q_reg),
        .wr_data   (shift_result)
    );

    msu_shifter u_shifter (
        .ctl        (ctl_reg),
        .sa         (sa_reg),
        .rs_val     (rs_val),
        .rt_val     (rt_val),
        .load_value (load_q_reg),
        .result     (shift_result)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            exec_reg <= exec_next;
            done_reg <= done_next;
        end
    end

    // Instruction fields held for the execute cycle, and the result beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg    <= decode_op(op);
            dest_q_reg <= dest_reg;
            sa_reg     <= shift_field;
            load_q_reg <= load_value;
        end
        if (exec_reg)
        begin
            out_dest_reg  <= dest_q_reg;
            out_value_reg <= shift_result;
            out_we_reg    <= (dest_q_reg != '0);
        end
    end

    assign busy         = exec_reg;
    assign done         = done_reg;
    assign written_reg  = out_dest_reg;
    assign result_value = out_value_reg;
    assign was_written  = out_we_reg;

endmodule

`default_nettype wire

FILE: sv/msu_checker.sv
`default_nettype none

module msu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [4:0] written_reg,
    input wire logic       was_written
);

    // Every accepted instruction yields its result beat once its execute cycle is over.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result beat missing two cycles after accept");

    // The unit is busy for exactly the cycle after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // A result beat never appears without an instruction in flight.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without an instruction");

    // Register zero is reported as not written, every other target as written.
    a_write_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (was_written == (written_reg != 5'd0)))
        else $error("write flag disagrees with target register");

endmodule

bind mips64_shift_unit msu_checker u_msu_checker (.*);

`default_nettype wire

FILE: tb/sv/msu_writeback_checker.sv
`timescale 1ns / 100ps

// Watches the instruction and write-back channels of the shift unit, keeps its
// own copy of the register file, and compares every write-back beat with the
// oldest predicted one.
module msu_writeback_checker
    import msu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [3:0]  op,
    input  wire logic [4:0]  dest_reg,
    input  wire logic [4:0]  value_reg,
    input  wire logic [4:0]  amount_reg,
    input  wire logic [4:0]  shift_field,
    input  wire logic [63:0] load_value,
    input  wire logic        done,
    input  wire logic [4:0]  written_reg,
    input  wire logic [63:0] result_value,
    input  wire logic        was_written,
    output int               mismatch_count,
    output int               outstanding
);

    typedef struct {
        logic [3:0]  code;
        logic [4:0]  reg_idx;
        logic [63:0] value;
        logic        wr;
    } writeback_t;

    writeback_t  writeback_q [$];
    logic [63:0] gpr_copy [32];

    function automatic logic [63:0] widen_word(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

    // Result of one instruction, given the operand register values it reads.
    function automatic logic [63:0] shift_result(
        input logic [3:0]  code,
        input logic [63:0] rt_val,
        input logic [63:0] rs_val,
        input logic [4:0]  sa,
        input logic [63:0] imm
    );
        logic [31:0] lo;
        logic [63:0] res;
        lo = rt_val[31:0];
        case (code)
            OP_SLL:    res = widen_word(lo << sa);
            OP_SRL:    res = widen_word(lo >> sa);
            OP_SRA:    res = widen_word($signed(lo) >>> sa);
            OP_DSLL:   res = rt_val << sa;
            OP_DSRL:   res = rt_val >> sa;
            OP_DSRA:   res = $signed(rt_val) >>> sa;
            OP_DSLL32: res = rt_val << {1'b1, sa};
            OP_DSRL32: res = rt_val >> {1'b1, sa};
            OP_DSRA32: res = $signed(rt_val) >>> {1'b1, sa};
            OP_SLLV:   res = widen_word(lo << rs_val[4:0]);
            OP_SRLV:   res = widen_word(lo >> rs_val[4:0]);
            OP_SRAV:   res = widen_word($signed(lo) >>> rs_val[4:0]);
            OP_DSLLV:  res = rt_val << rs_val[5:0];
            OP_DSRLV:  res = rt_val >> rs_val[5:0];
            OP_DSRAV:  res = $signed(rt_val) >>> rs_val[5:0];
            default:   res = imm;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        writeback_t wb;
        writeback_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                gpr_copy[i] = '0;
            writeback_q.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            // Register zero is never written, so its copy stays zero.
            if (start && !busy)
            begin
                wb.code = op;
                wb.reg_idx = dest_reg;
                wb.value = shift_result(op, gpr_copy[value_reg], gpr_copy[amount_reg],
                                        shift_field, load_value);
                wb.wr = (dest_reg != 5'd0);
                if (wb.wr)
                    gpr_copy[dest_reg] = wb.value;
                writeback_q.push_back(wb);
            end
            if (done)
            begin
                got.reg_idx = written_reg;
                got.value = result_value;
                got.wr = was_written;
                if (writeback_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("write-back beat with nothing pending: reg %0d value %h wr %b",
                                 got.reg_idx, got.value, got.wr);
                end
                else
                begin
                    wb = writeback_q.pop_front();
                    if (got.reg_idx !== wb.reg_idx || got.value !== wb.value
                        || got.wr !== wb.wr)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("op %0d: exp reg %0d %h wr %b, got reg %0d %h wr %b",
                                     wb.code, wb.reg_idx, wb.value, wb.wr,
                                     got.reg_idx, got.value, got.wr);
                    end
                end
            end
            outstanding = writeback_q.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

// Top level of the shift unit testbench. It only makes instruction beats and
// gives the verdict; the checker beside the unit does all prediction.
module tb;
    import msu_pkg::*;

    // One instruction beat as it goes onto the command channel.
    typedef struct {
        logic [3:0]  code;
        logic [4:0]  rd;
        logic [4:0]  rt;
        logic [4:0]  rs;
        logic [4:0]  sa;
        logic [63:0] imm;
    } instr_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  op;
    logic [4:0]  dest_reg;
    logic [4:0]  value_reg;
    logic [4:0]  amount_reg;
    logic [4:0]  shift_field;
    logic [63:0] load_value;
    logic        done;
    logic [4:0]  written_reg;
    logic [63:0] result_value;
    logic        was_written;
    int          mismatch_count;
    int          outstanding;

    // While set, the sender never leaves a gap between beats.
    bit          no_gaps;

    always #2 clk = ~clk;

    mips64_shift_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .dest_reg     (dest_reg),
        .value_reg    (value_reg),
        .amount_reg   (amount_reg),
        .shift_field  (shift_field),
        .load_value   (load_value),
        .done         (done),
        .written_reg  (written_reg),
        .result_value (result_value),
        .was_written  (was_written)
    );

    msu_writeback_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .dest_reg       (dest_reg),
        .value_reg      (value_reg),
        .amount_reg     (amount_reg),
        .shift_field    (shift_field),
        .load_value     (load_value),
        .done           (done),
        .written_reg    (written_reg),
        .result_value   (result_value),
        .was_written    (was_written),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    function automatic instr_t mk(input logic [3:0] code, input logic [4:0] rd,
                                  input logic [4:0] rt, input logic [4:0] rs,
                                  input logic [4:0] sa, input logic [63:0] imm);
        instr_t b;
        b.code = code;
        b.rd = rd;
        b.rt = rt;
        b.rs = rs;
        b.sa = sa;
        b.imm = imm;
        return b;
    endfunction

    // Random beat. About a quarter are loads, so the register file keeps
    // changing and the variable forms see fresh shift amounts. Load values
    // lean toward the patterns that stress sign handling and small amounts.
    function automatic instr_t random_instr();
        instr_t b;
        b.code = ($urandom_range(3) == 0) ? OP_LOAD : 4'($urandom_range(14));
        b.rd = 5'($urandom_range(31));
        b.rt = 5'($urandom_range(31));
        b.rs = 5'($urandom_range(31));
        b.sa = 5'($urandom_range(31));
        case ($urandom_range(7))
            0:       b.imm = '1;
            1:       b.imm = 64'h8000_0000_0000_0000;
            2:       b.imm = 64'($urandom_range(127));
            3:       b.imm = {32'h0, $urandom()};
            4:       b.imm = {$urandom(), 1'b1, 31'($urandom())};
            default: b.imm = {$urandom(), $urandom()};
        endcase
        return b;
    endfunction

    // Put one beat on the channel and return at the edge that accepts it.
    // Must be called right after a rising edge. A gap, when taken, drops
    // start and shows junk on the fields, which the unit has to ignore.
    task automatic issue(input instr_t b);
        if (!no_gaps && $urandom_range(99) < 18)
        begin
            start <= 1'b0;
            op <= 4'($urandom());
            dest_reg <= 5'($urandom());
            load_value <= {$urandom(), $urandom()};
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start <= 1'b1;
        op <= b.code;
        dest_reg <= b.rd;
        value_reg <= b.rt;
        amount_reg <= b.rs;
        shift_field <= b.sa;
        load_value <= b.imm;
        // Busy is read before the edge updates it, which is the value the
        // unit used to decide whether it took the beat.
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        op <= OP_SLL;
        dest_reg <= '0;
        value_reg <= '0;
        amount_reg <= '0;
        shift_field <= '0;
        load_value <= '0;
        no_gaps = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. First seed registers with edge patterns: all ones,
        // top and bottom bits, a word with bit 31 clear, a word with only
        // bit 31 set, an amount register holding 63 and one whose low six
        // bits are zero. A load to register zero must not stick.
        issue(mk(OP_LOAD, 5'd1, 5'd9, 5'd3, 5'd7, 64'hFFFF_FFFF_FFFF_FFFF));
        issue(mk(OP_LOAD, 5'd2, 5'd0, 5'd0, 5'd0, 64'h8000_0000_0000_0001));
        issue(mk(OP_LOAD, 5'd3, 5'd0, 5'd0, 5'd0, 64'h0000_0000_7FFF_FFFF));
        issue(mk(OP_LOAD, 5'd4, 5'd0, 5'd0, 5'd0, 64'd63));
        issue(mk(OP_LOAD, 5'd5, 5'd0, 5'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFC0));
        issue(mk(OP_LOAD, 5'd0, 5'd0, 5'd0, 5'd0, 64'h5A5A_A5A5_0F0F_F0F0));
        issue(mk(OP_LOAD, 5'd6, 5'd0, 5'd0, 5'd0, 64'h0000_0000_8000_0000));

        // Every shift form, most with the amount at zero or at its maximum. The
        // constant forms get junk in rs and the variable forms junk in sa.
        issue(mk(OP_SLL,    5'd7,  5'd6, 5'd1, 5'd0,  '1));
        issue(mk(OP_SLL,    5'd8,  5'd3, 5'd4, 5'd31, '0));
        issue(mk(OP_SRL,    5'd9,  5'd1, 5'd2, 5'd31, '1));
        issue(mk(OP_SRA,    5'd10, 5'd6, 5'd4, 5'd31, '0));
        issue(mk(OP_DSLL,   5'd11, 5'd1, 5'd4, 5'd31, '1));
        issue(mk(OP_DSRL,   5'd12, 5'd2, 5'd1, 5'd0,  '0));
        // Arithmetic doubleword shift aimed at register zero.
        issue(mk(OP_DSRA,   5'd0,  5'd2, 5'd1, 5'd5,  '1));
        issue(mk(OP_DSLL32, 5'd13, 5'd2, 5'd4, 5'd31, '0));
        issue(mk(OP_DSRL32, 5'd14, 5'd1, 5'd4, 5'd31, '1));
        issue(mk(OP_DSRA32, 5'd15, 5'd2, 5'd4, 5'd0,  '0));
        issue(mk(OP_SLLV,   5'd16, 5'd6, 5'd4, 5'd9,  '1));
        issue(mk(OP_SRLV,   5'd17, 5'd1, 5'd5, 5'd31, '0));
        issue(mk(OP_SRAV,   5'd18, 5'd6, 5'd4, 5'd3,  '1));
        issue(mk(OP_DSLLV,  5'd19, 5'd1, 5'd4, 5'd0,  '0));
        issue(mk(OP_DSRLV,  5'd20, 5'd2, 5'd4, 5'd31, '1));
        issue(mk(OP_DSRAV,  5'd21, 5'd2, 5'd4, 5'd1,  '0));
        // Register zero as the amount source and as the shifted value.
        issue(mk(OP_DSRAV,  5'd22, 5'd1, 5'd0, 5'd31, '1));
        issue(mk(OP_SRA,    5'd23, 5'd0, 5'd7, 5'd7,  '0));

        // Random part, with one long stretch of back-to-back beats.
        for (int n = 0; n < 1950; n++)
        begin
            no_gaps = (n >= 700 && n < 1100);
            issue(random_instr());
        end
        start <= 1'b0;

        // Drain: sample on the falling edge so the checker has settled.
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop in case the unit stops accepting or answering.
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: mips64_shift_unit.f
sv/msu_pkg.sv
sv/msu_regfile.sv
sv/msu_shifter.sv
sv/mips64_shift_unit.sv
sv/msu_checker.sv
tb/sv/msu_writeback_checker.sv
tb/sv/tb.sv
